[rtl/core/ffha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, status codes and controller/datapath command types.
// ---------------------------------------------------------------------------
package ffha_pkg;

    localparam int MaxBlocks   = 64;
    localparam int HeaderBytes = 32;
    localparam int AlignBytes  = 8;
    localparam int IdxW        = $clog2(MaxBlocks);
    localparam int CntW        = $clog2(MaxBlocks + 1);

    typedef enum logic [3:0] {
        ST_EXACT    = 4'd0,
        ST_SPLIT    = 4'd1,
        ST_NEW      = 4'd2,
        ST_BADSIZE  = 4'd3,
        ST_NOMEM    = 4'd4,
        ST_FULL     = 4'd5,
        ST_RETURNED = 4'd6,
        ST_KEPT     = 4'd7,
        ST_NOTFOUND = 4'd8
    } status_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture request, set index 0
        OP_READ,      // read entry at index into entry register
        OP_NEXT,      // index <= index + 1
        OP_PREV,      // index <= index - 1
        OP_SETBUSY,   // write entry at index busy, length kept
        OP_SPLIT_HI,  // write entry at index as busy with rounded size
        OP_APPEND,    // write new entry at count, raise break
        OP_MOVE_UP,   // mem[idx] <= held entry, held <= read entry, idx++
        OP_MOVE_DOWN, // mem[idx-1] (or idx-2 when far) <= read entry, idx++
        OP_HOLD,      // held entry <= read entry, marked free
        OP_MERGE,     // held length grows by read length plus header
        OP_MERGE_LO,  // as merge, but the held entry takes the read start
        OP_STORE,     // write held entry at index
        OP_RETURN,    // lower break to held entry, count <= index
        OP_DONE       // latch result
    } op_t;

    typedef struct packed {
        op_t      op;
        status_t  status;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     sel_addr;
        logic     far;
    } dp_cmd_t;

    typedef struct packed {
        logic     is_free;
        logic     size_zero;
        logic     size_ovf;
        logic     busy;
        logic     exact;
        logic     splits;
        logic     match;
        logic     idx_end;
        logic     idx_zero;
        logic     full;
        logic     nomem;
    } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/ffha_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Allocator channel interfaces
// Valid/ready channels for request and result beats.
// ---------------------------------------------------------------------------
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] req_size;
    logic [31:0] free_addr;
    modport source (output valid, func, req_size, free_addr, input ready);
    modport sink (input valid, func, req_size, free_addr, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] addr;
    logic [31:0] returned_bytes;
    logic [6:0]  block_total;
    modport source (output valid, status, addr, returned_bytes, block_total, input ready);
    modport sink (input valid, status, addr, returned_bytes, block_total, output ready);
endinterface
`default_nettype wire

[rtl/core/first_fit_heap_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// First-fit heap allocator core
// Address-ordered block table with split on allocate and merge on free.
//
//   Channel   Role    Beat carries
//   req       sink    func, req_size, free_addr
//   rsp       source  status, addr, returned_bytes, block_total
//   cfg       write   heap_limit
//
// One request at a time. An allocate searches the table entry by entry, and
// a split then shifts the tail up one entry at a time. A free searches
// likewise, merges with its neighbours and closes merged slots by a
// downward shift. The result beat holds until taken and the next request
// waits for it; reset empties the table and the break.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_core
    import ffha_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffha_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .func         (req.func),
        .req_size     (req.req_size),
        .free_addr    (req.free_addr),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .stat         (stat),
        .res_status   (rsp.status),
        .res_addr     (rsp.addr),
        .res_returned (rsp.returned_bytes),
        .res_total    (rsp.block_total)
    );

endmodule
`default_nettype wire

[rtl/core/ffha_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Allocator datapath
// Block table memory, working index, held entry, break and result registers.
// ---------------------------------------------------------------------------
module ffha_datapath
    import ffha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        func,
    input  wire logic [31:0] req_size,
    input  wire logic [31:0] free_addr,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output logic [3:0]       res_status,
    output logic [31:0]      res_addr,
    output logic [31:0]      res_returned,
    output logic [6:0]       res_total
);

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic        busy;
    } entry_t;

    entry_t      mem [MaxBlocks];
    entry_t      ent_reg;       // registered read of mem[idx]
    entry_t      hold_reg;      // entry being moved or merged
    logic [IdxW:0] idx_reg;
    logic [CntW-1:0] cnt_reg;
    logic [31:0] brk_reg;
    logic [31:0] limit_reg;
    logic        func_reg;
    logic [32:0] size_reg;
    logic [31:0] where_reg;
    logic [31:0] addr_reg;
    logic [31:0] ret_reg;
    logic [IdxW-1:0] widx;
    logic [IdxW-1:0] wdst;
    logic [33:0] end_sum;
    logic [33:0] split_need;

    assign widx       = idx_reg[IdxW-1:0];
    assign wdst       = widx - (cmd.far ? IdxW'(2) : IdxW'(1));
    assign end_sum    = {2'b00, brk_reg} + 34'(HeaderBytes) + {1'b0, size_reg};
    assign split_need = {1'b0, size_reg} + 34'(HeaderBytes);

    // Status flags towards the controller.
    always_comb
    begin
        stat.is_free   = func_reg;
        stat.size_zero = (size_reg == 33'd0);
        stat.size_ovf  = size_reg[32];
        stat.busy      = ent_reg.busy;
        stat.exact     = ({1'b0, ent_reg.length} == size_reg);
        stat.splits    = ({2'b00, ent_reg.length} > split_need);
        stat.match     = ((ent_reg.start + 32'(HeaderBytes)) == where_reg)
                         && (ent_reg.start <= 32'hFFFF_FFFF - 32'(HeaderBytes));
        stat.idx_end   = (CntW'(idx_reg) >= cnt_reg);
        stat.idx_zero  = (idx_reg == '0);
        stat.full      = (cnt_reg >= CntW'(MaxBlocks));
        stat.nomem     = (end_sum > {2'b00, limit_reg});
    end

    // Table memory: one write port.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_SETBUSY:   mem[widx] <= '{ent_reg.start, ent_reg.length, 1'b1};
            OP_SPLIT_HI:  mem[widx] <= '{ent_reg.start, size_reg[31:0], 1'b1};
            OP_APPEND:    mem[cnt_reg[IdxW-1:0]] <= '{brk_reg, size_reg[31:0], 1'b1};
            OP_MOVE_UP:   mem[widx] <= hold_reg;
            OP_MOVE_DOWN: mem[wdst] <= ent_reg;
            OP_STORE:     mem[widx] <= hold_reg;
            default:      ;
        endcase
        if (cmd.op == OP_READ)
        begin
            ent_reg <= mem[widx];
        end
    end

    // Index, count, break, held entry and results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            cnt_reg   <= '0;
            brk_reg   <= '0;
            limit_reg <= 32'hFFFF_FFFF;
            func_reg  <= 1'b0;
            size_reg  <= '0;
            where_reg <= '0;
            addr_reg  <= '0;
            ret_reg   <= '0;
            hold_reg  <= '0;
            res_status <= '0;
            res_addr  <= '0;
            res_returned <= '0;
            res_total <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - (cmd.far ? CntW'(2) : CntW'(1));
            end
            if (cmd.sel_addr)
            begin
                addr_reg <= ent_reg.start + 32'(HeaderBytes);
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    idx_reg   <= '0;
                    func_reg  <= func;
                    size_reg  <= ({1'b0, req_size} + 33'(AlignBytes - 1))
                                 & ~33'(AlignBytes - 1);
                    where_reg <= free_addr;
                    addr_reg  <= '0;
                    ret_reg   <= '0;
                end
                OP_NEXT:     idx_reg <= idx_reg + 1'b1;
                OP_PREV:     idx_reg <= idx_reg - 1'b1;
                OP_SPLIT_HI:
                begin
                    // Remainder block goes in at idx+1 via the upward shift.
                    hold_reg <= '{ent_reg.start + 32'(HeaderBytes) + size_reg[31:0],
                                  ent_reg.length - size_reg[31:0] - 32'(HeaderBytes),
                                  1'b0};
                    addr_reg <= ent_reg.start + 32'(HeaderBytes);
                end
                OP_APPEND:
                begin
                    addr_reg <= brk_reg + 32'(HeaderBytes);
                    brk_reg  <= end_sum[31:0];
                end
                OP_MOVE_UP:
                begin
                    hold_reg <= ent_reg;
                    idx_reg  <= idx_reg + 1'b1;
                end
                OP_MOVE_DOWN: idx_reg <= idx_reg + 1'b1;
                OP_HOLD:     hold_reg <= '{ent_reg.start, ent_reg.length, 1'b0};
                OP_MERGE:
                begin
                    hold_reg.length <= hold_reg.length + ent_reg.length
                                       + 32'(HeaderBytes);
                end
                OP_MERGE_LO:
                begin
                    // A free left neighbour becomes the head of the merged block.
                    hold_reg <= '{ent_reg.start,
                                  hold_reg.length + ent_reg.length + 32'(HeaderBytes),
                                  1'b0};
                end
                OP_RETURN:
                begin
                    brk_reg <= hold_reg.start;
                    ret_reg <= hold_reg.length;
                    cnt_reg <= CntW'(idx_reg);
                end
                OP_DONE:
                begin
                    res_status   <= cmd.status;
                    res_addr     <= (cmd.status == ST_EXACT || cmd.status == ST_SPLIT
                                     || cmd.status == ST_NEW) ? addr_reg : 32'd0;
                    res_returned <= (cmd.status == ST_RETURNED) ? ret_reg : 32'd0;
                    res_total    <= 7'(cnt_reg);
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/ffha_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Allocator controller
// Sequences the table walk, shifts, merges and the result beat.
// ---------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_ARD, S_AEVAL, S_SPLIT, S_SHUP_RD, S_SHUP_WR, S_APPEND,
        S_FRD, S_FEVAL, S_R_NX, S_R_CHK, S_R_EVAL, S_R_NX2, S_R_END, S_L_BACK,
        S_L_CHK, S_L_RD, S_L_EVAL, S_FIN, S_SKIP, S_SKIP2, S_SH_NX, S_SH_CHK,
        S_SH_WR, S_DONE, S_OUT
    } state_t;

    state_t    state_reg, state_next;
    dp_cmd_t   cmd_next;
    status_t   st_reg, st_next;
    logic      out_valid_next;
    logic      left_reg, left_next;   // free left neighbour merged
    logic      right_reg, right_next; // free right neighbour merged
    logic      last_reg, last_next;   // merged block ends the table

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        left_next  = left_reg;
        right_next = right_reg;
        last_next  = last_reg;
        cmd_next   = '{OP_NONE, ST_EXACT, 1'b0, 1'b0, 1'b0, 1'b0};
        out_valid_next = out_valid;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd_next.op = OP_LOAD;
                    state_next  = S_CHECK;
                end
            S_CHECK:
                if (stat.is_free)
                begin
                    state_next = S_FRD;
                end
                else if (stat.size_zero)
                begin
                    st_next = ST_BADSIZE; state_next = S_DONE;
                end
                else if (stat.size_ovf)
                begin
                    st_next = ST_NOMEM; state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ARD;
                end
            S_ARD:
                if (stat.idx_end)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd_next.op = OP_READ; state_next = S_AEVAL;
                end
            S_AEVAL:
                if (stat.busy)
                begin
                    cmd_next.op = OP_NEXT; state_next = S_ARD;
                end
                else if (stat.exact)
                begin
                    cmd_next.op = OP_SETBUSY; cmd_next.sel_addr = 1'b1;
                    st_next = ST_EXACT; state_next = S_DONE;
                end
                else if (stat.splits)
                begin
                    if (stat.full)
                    begin
                        st_next = ST_FULL; state_next = S_DONE;
                    end
                    else
                    begin
                        cmd_next.op = OP_SPLIT_HI; st_next = ST_SPLIT;
                        state_next = S_SPLIT;
                    end
                end
                else
                begin
                    cmd_next.op = OP_NEXT; state_next = S_ARD;
                end
            S_SPLIT:
            begin
                // Walk upward inserting the remainder and carrying each entry.
                cmd_next.op = OP_NEXT; state_next = S_SHUP_RD;
            end
            S_SHUP_RD:
                if (stat.idx_end)
                begin
                    cmd_next.op = OP_STORE; cmd_next.cnt_inc = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd_next.op = OP_READ; state_next = S_SHUP_WR;
                end
            S_SHUP_WR:
            begin
                cmd_next.op = OP_MOVE_UP; state_next = S_SHUP_RD;
            end
            S_APPEND:
                if (stat.nomem)
                begin
                    st_next = ST_NOMEM; state_next = S_DONE;
                end
                else if (stat.full)
                begin
                    st_next = ST_FULL; state_next = S_DONE;
                end
                else
                begin
                    cmd_next.op = OP_APPEND; cmd_next.cnt_inc = 1'b1;
                    st_next = ST_NEW; state_next = S_DONE;
                end
            // Free: search for the entry whose payload offset matches.
            S_FRD:
                if (stat.idx_end)
                begin
                    st_next = ST_NOTFOUND; state_next = S_DONE;
                end
                else
                begin
                    cmd_next.op = OP_READ; state_next = S_FEVAL;
                end
            S_FEVAL:
                if (stat.match)
                begin
                    cmd_next.op = OP_HOLD; state_next = S_R_NX;
                    left_next = 1'b0; right_next = 1'b0; last_next = 1'b0;
                end
                else
                begin
                    cmd_next.op = OP_NEXT; state_next = S_FRD;
                end
            // Right neighbour first; also find out whether the merge reaches the end.
            S_R_NX:
            begin
                cmd_next.op = OP_NEXT; state_next = S_R_CHK;
            end
            S_R_CHK:
                if (stat.idx_end)
                begin
                    last_next = 1'b1; state_next = S_L_BACK;
                end
                else
                begin
                    cmd_next.op = OP_READ; state_next = S_R_EVAL;
                end
            S_R_EVAL:
                if (!stat.busy)
                begin
                    cmd_next.op = OP_MERGE; right_next = 1'b1; state_next = S_R_NX2;
                end
                else
                begin
                    state_next = S_L_BACK;
                end
            S_R_NX2:
            begin
                cmd_next.op = OP_NEXT; state_next = S_R_END;
            end
            S_R_END:
            begin
                last_next = stat.idx_end;
                cmd_next.op = OP_PREV; state_next = S_L_BACK;
            end
            S_L_BACK:
            begin
                cmd_next.op = OP_PREV; state_next = S_L_CHK;
            end
            // Left neighbour; the index ends on the head of the merged block.
            S_L_CHK:
                if (stat.idx_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd_next.op = OP_PREV; state_next = S_L_RD;
                end
            S_L_RD:
            begin
                cmd_next.op = OP_READ; state_next = S_L_EVAL;
            end
            S_L_EVAL:
                if (!stat.busy)
                begin
                    cmd_next.op = OP_MERGE_LO; left_next = 1'b1; state_next = S_FIN;
                end
                else
                begin
                    cmd_next.op = OP_NEXT; state_next = S_FIN;
                end
            S_FIN:
                if (last_reg)
                begin
                    // Merged block is the tail: drop it and lower the break.
                    cmd_next.op = OP_RETURN; st_next = ST_RETURNED; state_next = S_DONE;
                end
                else
                begin
                    cmd_next.op = OP_STORE; st_next = ST_KEPT;
                    state_next = (left_reg || right_reg) ? S_SKIP : S_DONE;
                end
            // Step past the absorbed slots to the first entry that moves down.
            S_SKIP:
            begin
                cmd_next.op = OP_NEXT;
                state_next  = (left_reg && right_reg) ? S_SKIP2 : S_SH_NX;
            end
            S_SKIP2:
            begin
                cmd_next.op = OP_NEXT; state_next = S_SH_NX;
            end
            S_SH_NX:
            begin
                cmd_next.op = OP_NEXT; state_next = S_SH_CHK;
            end
            S_SH_CHK:
                if (stat.idx_end)
                begin
                    cmd_next.cnt_dec = 1'b1; cmd_next.far = left_reg && right_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd_next.op = OP_READ; state_next = S_SH_WR;
                end
            S_SH_WR:
            begin
                cmd_next.op  = OP_MOVE_DOWN;
                cmd_next.far = left_reg && right_reg;
                state_next   = S_SH_CHK;
            end
            S_DONE:
            begin
                cmd_next.op = OP_DONE; cmd_next.status = st_reg;
                out_valid_next = 1'b1; state_next = S_OUT;
            end
            S_OUT:
                if (out_ready)
                begin
                    out_valid_next = 1'b0; state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // State and registered flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_EXACT;
            left_reg  <= 1'b0;
            right_reg <= 1'b0;
            last_reg  <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            last_reg  <= last_next;
            out_valid <= out_valid_next;
        end
    end

    assign cmd = cmd_next;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// First-fit heap allocator core testbench
// A directed table of requests comes first, followed by random allocate and
// free traffic under several heap limits. Every result beat is checked against
// its typed row's answer or a local model of the block table, break and heap limit.
// ---------------------------------------------------------------------------
module tb_top;
    import ffha_pkg::*;

    localparam int       NumBlocks   = 64;
    localparam int       HdrBytes    = 32;
    localparam int       MaxCycles   = 2000000;
    localparam int       PhaseItems  = 300;
    localparam int       DrainCycles = 600;
    localparam int       NumRows     = 19;
    localparam bit       FuncAlloc   = 1'b0;
    localparam bit       FuncFree    = 1'b1;

    typedef struct {
        status_t     st;
        logic [31:0] addr;
        logic [31:0] ret;
        logic [6:0]  total;
    } outcome_t;

    typedef struct {
        bit          func;
        logic [31:0] size;
        logic [31:0] where;
        bit          typed;
        outcome_t    want;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    ffha_req_if req ();
    ffha_rsp_if rsp ();

    first_fit_heap_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Model of the block table
    logic [31:0] blk_start [NumBlocks];
    logic [31:0] blk_len [NumBlocks];
    bit          blk_busy [NumBlocks];
    int unsigned blk_count;
    logic [31:0] heap_brk;
    logic [31:0] heap_cap;

    outcome_t    pending_results [$];
    row_t        rows [NumRows];
    int          mismatches;
    int          beats_checked;
    int          cycle_count;
    bit          send_gaps;
    bit          sink_stalls;
    int          stall_left;
    int          status_seen [16];

    always #4 clk = ~clk;

    // Insert an empty slot at pos, shifting the tail up.
    function automatic void open_gap(int unsigned pos);
        int unsigned k;
        for (k = blk_count; k > pos; k--)
        begin
            blk_start[k] = blk_start[k-1];
            blk_len[k]   = blk_len[k-1];
            blk_busy[k]  = blk_busy[k-1];
        end
        blk_count++;
    endfunction

    // Remove the slot at pos, shifting the tail down.
    function automatic void close_gap(int unsigned pos);
        int unsigned k;
        for (k = pos; k + 1 < blk_count; k++)
        begin
            blk_start[k] = blk_start[k+1];
            blk_len[k]   = blk_len[k+1];
            blk_busy[k]  = blk_busy[k+1];
        end
        blk_count--;
    endfunction

    function automatic outcome_t grant_block(logic [31:0] size_in);
        logic [63:0] sz;
        logic [63:0] fin;
        logic [31:0] old;
        int unsigned i;
        outcome_t o;
        o.addr = '0;
        o.ret  = '0;
        if (size_in == 0)
        begin
            o.st = ST_BADSIZE;
            return o;
        end
        sz = (64'(size_in) + 64'd7) & ~64'd7;
        if (sz > 64'hFFFF_FFFF)
        begin
            o.st = ST_NOMEM;
            return o;
        end
        // First fit: the first free block that fits exactly or is worth splitting.
        for (i = 0; i < blk_count; i++)
        begin
            if (blk_busy[i])
                continue;
            if (64'(blk_len[i]) == sz)
            begin
                blk_busy[i] = 1'b1;
                o.st   = ST_EXACT;
                o.addr = blk_start[i] + HdrBytes;
                return o;
            end
            if (64'(blk_len[i]) > sz + HdrBytes)
            begin
                if (blk_count >= NumBlocks)
                begin
                    o.st = ST_FULL;
                    return o;
                end
                old = blk_len[i];
                open_gap(i + 1);
                blk_start[i+1] = blk_start[i] + HdrBytes + sz[31:0];
                blk_len[i+1]   = old - sz[31:0] - HdrBytes;
                blk_busy[i+1]  = 1'b0;
                blk_len[i]     = sz[31:0];
                blk_busy[i]    = 1'b1;
                o.st   = ST_SPLIT;
                o.addr = blk_start[i] + HdrBytes;
                return o;
            end
        end
        // Nothing reusable, so append at the break.
        fin = 64'(heap_brk) + HdrBytes + sz;
        if (fin > 64'(heap_cap))
        begin
            o.st = ST_NOMEM;
            return o;
        end
        if (blk_count >= NumBlocks)
        begin
            o.st = ST_FULL;
            return o;
        end
        blk_start[blk_count] = heap_brk;
        blk_len[blk_count]   = sz[31:0];
        blk_busy[blk_count]  = 1'b1;
        blk_count++;
        heap_brk = fin[31:0];
        o.st   = ST_NEW;
        o.addr = blk_start[blk_count-1] + HdrBytes;
        return o;
    endfunction

    function automatic outcome_t release_block(logic [31:0] where);
        int unsigned i;
        outcome_t o;
        o.addr = '0;
        o.ret  = '0;
        for (i = 0; i < blk_count; i++)
        begin
            if (64'(blk_start[i]) + HdrBytes == 64'(where))
                break;
        end
        if (i >= blk_count)
        begin
            o.st = ST_NOTFOUND;
            return o;
        end
        blk_busy[i] = 1'b0;
        // Merge into a free left neighbour, then absorb a free right one.
        if (i > 0 && !blk_busy[i-1])
        begin
            blk_len[i-1] = blk_len[i-1] + blk_len[i] + HdrBytes;
            close_gap(i);
            i--;
        end
        if (i + 1 < blk_count && !blk_busy[i+1])
        begin
            blk_len[i] = blk_len[i] + blk_len[i+1] + HdrBytes;
            close_gap(i + 1);
        end
        if (i + 1 == blk_count)
        begin
            o.ret    = blk_len[i];
            heap_brk = blk_start[i];
            close_gap(i);
            o.st = ST_RETURNED;
            return o;
        end
        o.st = ST_KEPT;
        return o;
    endfunction

    function automatic outcome_t predict_heap(bit func, logic [31:0] size_in,
                                              logic [31:0] where);
        outcome_t o;
        o = (func == FuncAlloc) ? grant_block(size_in) : release_block(where);
        o.total = blk_count[6:0];
        return o;
    endfunction

    // Present one request beat and wait for it to be taken.
    task automatic issue_request(bit func, logic [31:0] size_in, logic [31:0] where,
                                 bit typed, outcome_t want);
        outcome_t o;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.func      <= func;
        req.req_size  <= size_in;
        req.free_addr <= where;
        do
            @(posedge clk);
        while (!req.ready);
        o = predict_heap(func, size_in, where);
        pending_results.push_back(typed ? want : o);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [31:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        heap_cap = value;
    endtask

    // Random traffic; alloc_pct sets the share of allocate requests.
    task automatic random_traffic(int count, int alloc_pct);
        logic [31:0] sz;
        logic [31:0] where;
        int unsigned pick;
        outcome_t    none;
        int          n;
        none = '{ST_EXACT, '0, '0, '0};
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                if (pick < 60)
                    sz = $urandom_range(1, 200);
                else if (pick < 80 && blk_count > 0)
                    sz = blk_len[$urandom_range(0, blk_count - 1)];
                else if (pick < 90)
                    sz = $urandom_range(1, 2000);
                else if (pick < 95)
                    sz = $urandom;
                else
                    sz = 0;
                issue_request(FuncAlloc, sz, $urandom, 1'b0, none);
            end
            else
            begin
                if (pick < 85 && blk_count > 0)
                    where = blk_start[$urandom_range(0, blk_count - 1)] + HdrBytes;
                else if (pick < 92)
                    where = $urandom;
                else
                    where = $urandom_range(0, 4096);
                issue_request(FuncFree, $urandom, where, 1'b0, none);
            end
        end
    endtask

    // Result sink: random stall bursts, held ready when stalls are off.
    always @(posedge clk)
    begin
        if (!rst_n || !sink_stalls)
            rsp.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready  <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            rsp.ready  <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat, status %0d", rsp.status);
            end
            else
            begin
                e = pending_results.pop_front();
                beats_checked++;
                status_seen[rsp.status]++;
                if (rsp.status !== e.st || rsp.addr !== e.addr ||
                    rsp.returned_bytes !== e.ret || rsp.block_total !== e.total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: beat %0d expected st=%0d addr=%h ret=%h n=%0d, got st=%0d addr=%h ret=%h n=%0d",
                                 beats_checked, e.st, e.addr, e.ret, e.total,
                                 rsp.status, rsp.addr, rsp.returned_bytes,
                                 rsp.block_total);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MaxCycles)
        begin
            $display("ERROR: run limit reached with %0d results pending",
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int r;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        req.valid     = 1'b0;
        req.func      = 1'b0;
        req.req_size  = '0;
        req.free_addr = '0;
        rsp.ready   = 1'b1;
        mismatches  = 0;
        beats_checked = 0;
        cycle_count = 0;
        stall_left  = 0;
        send_gaps   = 1'b1;
        sink_stalls = 1'b1;
        blk_count   = 0;
        heap_brk    = '0;
        heap_cap    = 32'hFFFF_FFFF;
        foreach (status_seen[s])
            status_seen[s] = 0;

        // Directed requests; typed rows carry the obvious answer.
        rows[0]  = '{FuncAlloc, 32'h0,         32'h0, 1, '{ST_BADSIZE, 0, 0, 0}};
        rows[1]  = '{FuncAlloc, 32'hFFFF_FFFF, 32'h0, 1, '{ST_NOMEM, 0, 0, 0}};
        rows[2]  = '{FuncAlloc, 32'hFFFF_FFF9, 32'h0, 1, '{ST_NOMEM, 0, 0, 0}};
        rows[3]  = '{FuncFree,  32'h0, 32'h0,         1, '{ST_NOTFOUND, 0, 0, 0}};
        rows[4]  = '{FuncFree,  32'h0, 32'hFFFF_FFFF, 1, '{ST_NOTFOUND, 0, 0, 0}};
        rows[5]  = '{FuncAlloc, 32'd1,   32'h0, 1, '{ST_NEW, 32, 0, 1}};
        rows[6]  = '{FuncAlloc, 32'd100, 32'h0, 1, '{ST_NEW, 72, 0, 2}};
        rows[7]  = '{FuncAlloc, 32'd8,   32'h0, 1, '{ST_NEW, 208, 0, 3}};
        rows[8]  = '{FuncAlloc, 32'hFFFF_FFF0, 32'h0, 1, '{ST_NOMEM, 0, 0, 3}};
        rows[9]  = '{FuncFree,  32'h0, 32'd72, 1, '{ST_KEPT, 0, 0, 3}};
        rows[10] = '{FuncAlloc, 32'd104, 32'h0, 1, '{ST_EXACT, 72, 0, 3}};
        rows[11] = '{FuncFree,  32'h0, 32'd72, 1, '{ST_KEPT, 0, 0, 3}};
        rows[12] = '{FuncAlloc, 32'd16,  32'h0, 1, '{ST_SPLIT, 72, 0, 4}};
        rows[13] = '{FuncFree,  32'h0, 32'd32,  0, '{ST_EXACT, 0, 0, 0}};
        rows[14] = '{FuncFree,  32'h0, 32'd72,  0, '{ST_EXACT, 0, 0, 0}};
        rows[15] = '{FuncFree,  32'h0, 32'd32,  0, '{ST_EXACT, 0, 0, 0}};
        rows[16] = '{FuncFree,  32'h0, 32'd208, 0, '{ST_EXACT, 0, 0, 0}};
        rows[17] = '{FuncAlloc, 32'h7FFF_FFF8, 32'h0, 0, '{ST_EXACT, 0, 0, 0}};
        rows[18] = '{FuncFree,  32'hFFFF_FFFF, 32'd32, 0, '{ST_EXACT, 0, 0, 0}};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < NumRows; r++)
            issue_request(rows[r].func, rows[r].size, rows[r].where,
                          rows[r].typed, rows[r].want);

        // Random phases under a spread of heap limits.
        write_limit(32'hFFFF_FFFF);
        random_traffic(PhaseItems, 90);
        write_limit(32'd2048);
        random_traffic(PhaseItems, 55);
        write_limit(32'h0);
        random_traffic(PhaseItems / 2, 55);
        write_limit(32'd600);
        random_traffic(PhaseItems / 2, 55);
        write_limit(32'hFFFF_FFFF);
        random_traffic(PhaseItems, 60);
        wait_drained();
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        random_traffic(PhaseItems, 60);

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        $display("Checked %0d result beats: exact %0d, split %0d, new %0d, full %0d,",
                 beats_checked, status_seen[ST_EXACT], status_seen[ST_SPLIT],
                 status_seen[ST_NEW], status_seen[ST_FULL]);
        $display("no memory %0d, returned %0d, kept %0d, not found %0d; mismatches %0d.",
                 status_seen[ST_NOMEM], status_seen[ST_RETURNED], status_seen[ST_KEPT],
                 status_seen[ST_NOTFOUND], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ffha_pkg.sv
rtl/core/ffha_if.sv
rtl/core/ffha_datapath.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator_core.sv
tb/tb_top.sv
